@@ rtl/core/wpd_pkg.sv @@
// shared types and constants for the windowed pair distance emitter
// no dependencies; used by wpd_seq, wpd_out_stage and the top level
package wpd_pkg;

    localparam int GAP_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 1'b1;

    localparam logic [GAP_W-1:0] MIN_GAP_RST = 16'd30;
    localparam logic [GAP_W-1:0] MAX_GAP_RST = 16'd2000;

    // one result word as it leaves the sequencer
    typedef struct packed {
        logic [GAP_W-1:0] distance;
        logic             last;
        logic             overflowed;
    } t_result;

endpackage

@@ rtl/core/wpd_window_ram.sv @@
// window store: single write port, single read port, registered read data
// no dependencies
module wpd_window_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 28,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/wpd_out_stage.sv @@
// output register between the sequencer and the result channel
// depends on wpd_pkg (t_result)
module wpd_out_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  wpd_pkg::t_result          i_word,
    output logic                      o_can_push,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [wpd_pkg::GAP_W-1:0] o_distance,
    output logic                      o_last,
    output logic                      o_window_overflowed
);

    logic             r_valid;
    wpd_pkg::t_result r_word;

    assign o_can_push = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

    assign o_valid             = r_valid;
    assign o_distance          = r_word.distance;
    assign o_last              = r_word.last;
    assign o_window_overflowed = r_word.overflowed;

endmodule

@@ rtl/core/wpd_seq.sv @@
// sequencer: prunes stale entries, scans the window newest first, inserts the new position
// depends on wpd_pkg (t_result, GAP_W); drives the ports of wpd_window_ram
module wpd_seq #(
    parameter int DEPTH = 64,
    parameter int PB    = 28,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [PB-1:0]             i_position,
    input  logic                      i_new_sequence,
    input  logic [wpd_pkg::GAP_W-1:0] i_min_gap,
    input  logic [wpd_pkg::GAP_W-1:0] i_max_gap,
    output logic                      o_mem_we,
    output logic [AW-1:0]             o_mem_waddr,
    output logic [PB-1:0]             o_mem_wdata,
    output logic                      o_mem_re,
    output logic [AW-1:0]             o_mem_raddr,
    input  logic [PB-1:0]             i_mem_rdata,
    input  logic                      i_can_push,
    output logic                      o_push,
    output wpd_pkg::t_result          o_push_word,
    output logic [CW-1:0]             o_count
);

    localparam int DW = (PB > wpd_pkg::GAP_W) ? PB : wpd_pkg::GAP_W;
    localparam int SW = AW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_SCAN,
        ST_INSERT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head,  n_head;
    logic [PB-1:0] r_prev,  n_prev;
    logic          r_prev_v, n_prev_v;
    logic          r_ovf,   n_ovf;
    logic [PB-1:0] r_p,     n_p;
    logic          r_evict, n_evict;
    logic [CW-1:0] r_k,     n_k;
    logic          r_s1_v,  n_s1_v;
    logic          r_s1_last, n_s1_last;

    logic [SW-1:0] w_newest_sum, w_oldest_sum;
    logic [AW-1:0] w_newest_slot, w_oldest_slot, w_head_inc;
    logic [DW-1:0] w_diff;
    logic          w_q_above, w_stale, w_qual, w_adv;

    // slot arithmetic modulo DEPTH; each sum stays below twice DEPTH
    assign w_newest_sum  = {1'b0, r_head} + SW'(DEPTH - 1) - SW'(r_k);
    assign w_oldest_sum  = {1'b0, r_head} + SW'(DEPTH) - SW'(r_count);
    assign w_newest_slot = (w_newest_sum >= SW'(DEPTH)) ? AW'(w_newest_sum - SW'(DEPTH))
                                                        : AW'(w_newest_sum);
    assign w_oldest_slot = (w_oldest_sum >= SW'(DEPTH)) ? AW'(w_oldest_sum - SW'(DEPTH))
                                                        : AW'(w_oldest_sum);
    assign w_head_inc    = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign w_q_above = i_mem_rdata > r_p;
    assign w_diff    = DW'(r_p) - DW'(i_mem_rdata);
    assign w_stale   = w_q_above || (w_diff > DW'(i_max_gap));
    // entries left after pruning all lie within max_gap
    assign w_qual    = r_s1_v && !w_q_above && (w_diff > DW'(i_min_gap));
    assign w_adv     = !(w_qual && !i_can_push);

    assign o_ready     = (r_state == ST_IDLE);
    assign o_mem_waddr = r_head;
    assign o_mem_wdata = r_p;
    assign o_count     = r_count;

    assign o_push_word.distance   = w_diff[wpd_pkg::GAP_W-1:0];
    assign o_push_word.last       = r_s1_last;
    assign o_push_word.overflowed = r_ovf;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_prev    = r_prev;
        n_prev_v  = r_prev_v;
        n_ovf     = r_ovf;
        n_p       = r_p;
        n_evict   = r_evict;
        n_k       = r_k;
        n_s1_v    = r_s1_v;
        n_s1_last = r_s1_last;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_raddr = w_newest_slot;
        o_push      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_new_sequence) begin
                        n_count  = '0;
                        n_head   = '0;
                        n_prev_v = 1'b0;
                        n_ovf    = 1'b0;
                        n_p      = i_position;
                        n_evict  = 1'b0;
                        n_state  = ST_INSERT;
                    end else if (!(r_prev_v && (i_position <= r_prev))) begin
                        n_p     = i_position;
                        n_evict = 1'b0;
                        n_state = (r_count == '0) ? ST_INSERT : ST_PRUNE_RD;
                    end
                end
            end
            ST_PRUNE_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = w_oldest_slot;
                n_state     = ST_PRUNE_CHK;
            end
            ST_PRUNE_CHK: begin
                if (w_stale) begin
                    n_count = r_count - CW'(1);
                    n_state = (r_count == CW'(1)) ? ST_INSERT : ST_PRUNE_RD;
                end else begin
                    // full window: oldest goes, but still joins this scan
                    if (r_count == CW'(DEPTH)) begin
                        n_evict = 1'b1;
                        if (w_diff < DW'(i_max_gap)) begin
                            n_ovf = 1'b1;
                        end
                    end
                    n_k     = '0;
                    n_s1_v  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_adv) begin
                    if (r_s1_v) begin
                        o_push = w_qual;
                        if (r_s1_last) begin
                            n_state = ST_INSERT;
                        end
                    end
                    if (r_k < r_count) begin
                        o_mem_re  = 1'b1;
                        n_k       = r_k + CW'(1);
                        n_s1_v    = 1'b1;
                        n_s1_last = (r_k == r_count - CW'(1));
                    end else begin
                        n_s1_v = 1'b0;
                    end
                end
            end
            ST_INSERT: begin
                o_mem_we = 1'b1;
                n_head   = w_head_inc;
                if (!r_evict) begin
                    n_count = r_count + CW'(1);
                end
                n_prev   = r_p;
                n_prev_v = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_prev    <= '0;
            r_prev_v  <= 1'b0;
            r_ovf     <= 1'b0;
            r_p       <= '0;
            r_evict   <= 1'b0;
            r_k       <= '0;
            r_s1_v    <= 1'b0;
            r_s1_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_head    <= n_head;
            r_prev    <= n_prev;
            r_prev_v  <= n_prev_v;
            r_ovf     <= n_ovf;
            r_p       <= n_p;
            r_evict   <= n_evict;
            r_k       <= n_k;
            r_s1_v    <= n_s1_v;
            r_s1_last <= n_s1_last;
        end
    end

endmodule

@@ rtl/core/windowed_pair_distance_emitter.sv @@
// top level: configuration registers, sequencer, window store and output register
// depends on wpd_pkg, wpd_window_ram, wpd_seq, wpd_out_stage
//
//  channel   signals                                         direction
//  input     i_valid/o_ready, i_position, i_new_sequence     in
//  result    o_valid/i_ready, o_distance, o_last,
//            o_window_overflowed                             out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                 in, write only
//
// one word at a time: accept, then a read and a check of the oldest entry for each stale
// entry pruned and for the first in-range entry, then a scan of the window newest first,
// then the insert; the single read port of the store paces prune and scan
// a dropped word (not ascending) is accepted and goes no further than idle
// reset is synchronous and active low; the window store needs no clearing pass
// a stalled result register holds the scan; the next word is taken while the last
// result still waits
module windowed_pair_distance_emitter #(
    parameter int WINDOW_DEPTH  = 64,
    parameter int POSITION_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [POSITION_BITS-1:0]      i_position,
    input  logic                          i_new_sequence,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [wpd_pkg::GAP_W-1:0]     o_distance,
    output logic                          o_last,
    output logic                          o_window_overflowed,
    input  logic                          i_cfg_we,
    input  logic [wpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wpd_pkg::GAP_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic [wpd_pkg::GAP_W-1:0] r_min_gap;
    logic [wpd_pkg::GAP_W-1:0] r_max_gap;

    logic                     w_mem_we, w_mem_re;
    logic [AW-1:0]            w_mem_waddr, w_mem_raddr;
    logic [POSITION_BITS-1:0] w_mem_wdata, w_mem_rdata;
    logic                     w_can_push, w_push;
    wpd_pkg::t_result         w_push_word;
    logic [CW-1:0]            w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= wpd_pkg::MIN_GAP_RST;
            r_max_gap <= wpd_pkg::MAX_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wpd_pkg::CFG_MIN_GAP: r_min_gap <= i_cfg_data;
                wpd_pkg::CFG_MAX_GAP: r_max_gap <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    wpd_window_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (POSITION_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    wpd_seq #(
        .DEPTH (WINDOW_DEPTH),
        .PB    (POSITION_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_position     (i_position),
        .i_new_sequence (i_new_sequence),
        .i_min_gap      (r_min_gap),
        .i_max_gap      (r_max_gap),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_re       (w_mem_re),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata),
        .i_can_push     (w_can_push),
        .o_push         (w_push),
        .o_push_word    (w_push_word),
        .o_count        (w_count)
    );

    wpd_out_stage u_out (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (w_push),
        .i_word              (w_push_word),
        .o_can_push          (w_can_push),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_distance          (o_distance),
        .o_last              (o_last),
        .o_window_overflowed (o_window_overflowed)
    );

    // the sequencer never overwrites a word that is still waiting
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_can_push)
        else $error("result pushed into a full output register");

    // the window never holds more entries than the store has
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(WINDOW_DEPTH))
        else $error("window count beyond store depth");

    // a new result only appears while a word is being worked on
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !o_ready)
        else $error("result produced while idle");

    // reads and the insert write never share a cycle
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !w_mem_re)
        else $error("window store read and written together");

endmodule

@@ test/tb_windowed_pair_distance_emitter.sv @@
// testbench for windowed_pair_distance_emitter: a directed table, then random position
// sequences across several gap settings, checked word by word against a window predictor
// depends on wpd_pkg and the windowed_pair_distance_emitter top level
module tb_windowed_pair_distance_emitter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH          = 64;
    localparam int          POS_W          = 28;
    localparam int          GW             = wpd_pkg::GAP_W;
    localparam int unsigned POS_MAX        = (1 << POS_W) - 1;
    // a word can prune a whole window, scan it and insert
    localparam int          SETTLE_CYCLES  = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          LONG_HOLD      = 400;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [POS_W-1:0]                 i_position = '0;
    logic                             i_new_sequence = 1'b0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic [GW-1:0]                    o_distance;
    logic                             o_last;
    logic                             o_window_overflowed;
    logic                             i_cfg_we = 1'b0;
    logic [wpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx = wpd_pkg::CFG_MIN_GAP;
    logic [GW-1:0]                    i_cfg_data = '0;

    windowed_pair_distance_emitter #(
        .WINDOW_DEPTH  (DEPTH),
        .POSITION_BITS (POS_W)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_position          (i_position),
        .i_new_sequence      (i_new_sequence),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_distance          (o_distance),
        .o_last              (o_last),
        .o_window_overflowed (o_window_overflowed),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // directed rows; typed rows carry at most one distance, always the last of its run
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             new_seq;
        logic             typed;
        logic             one_dist;
        logic [GW-1:0]    exp_gap;
    } t_row;

    localparam int N_ROWS = 24;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{28'h0000000, 1'b1, 1'b1, 1'b0, 16'd0},     // empty window
        '{28'h0000064, 1'b0, 1'b1, 1'b1, 16'd100},
        '{28'h0000064, 1'b0, 1'b1, 1'b0, 16'd0},     // repeat, dropped
        '{28'h0000032, 1'b0, 1'b1, 1'b0, 16'd0},     // descending, dropped
        '{28'h0000078, 1'b0, 1'b1, 1'b1, 16'd120},
        '{28'h0000082, 1'b0, 1'b1, 1'b1, 16'd130},   // 30 apart sits on min_gap
        '{28'h0000852, 1'b0, 1'b1, 1'b1, 16'd2000},  // stale entries pruned
        '{28'h0000853, 1'b0, 1'b1, 1'b0, 16'd0},     // nothing in range
        '{28'hFFFF000, 1'b1, 1'b1, 1'b0, 16'd0},
        '{28'hFFFF7D0, 1'b0, 1'b1, 1'b1, 16'd2000},
        '{28'hFFFFFFF, 1'b0, 1'b1, 1'b0, 16'd0},
        '{28'hFFFFFFF, 1'b0, 1'b1, 1'b0, 16'd0},
        '{28'h0000000, 1'b1, 1'b1, 1'b0, 16'd0},
        '{28'h000001F, 1'b0, 1'b1, 1'b1, 16'd31},
        '{28'h000003D, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h00000C8, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h00000E6, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h00000E7, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h00005DC, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h0000834, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h000000A, 1'b1, 1'b0, 1'b0, 16'd0},
        '{28'h000002D, 1'b0, 1'b0, 1'b0, 16'd0},
        '{28'h000002E, 1'b1, 1'b0, 1'b0, 16'd0},
        '{28'h000004D, 1'b0, 1'b0, 1'b0, 16'd0}
    };

    // window predictor state
    logic [POS_W-1:0] win_pos [DEPTH];
    int unsigned      win_cnt = 0;
    int unsigned      win_head = 0;
    int unsigned      prev_pos = 0;
    bit               prev_ok = 1'b0;
    bit               ovf_flag = 1'b0;
    logic [GW-1:0]    gap_lo = wpd_pkg::MIN_GAP_RST;
    logic [GW-1:0]    gap_hi = wpd_pkg::MAX_GAP_RST;

    wpd_pkg::t_result distance_run [$];
    wpd_pkg::t_result pending_distances [$];

    int  mismatches = 0;
    int  hold_cnt = 0;
    int  idle_cycles = 0;
    bit  hold_long = 1'b0;
    bit  quiet = 1'b0;

    // works out the run of distances one accepted position causes and updates the window
    function automatic void step_window(input logic [POS_W-1:0] pos, input logic new_seq);
        int unsigned      p;
        int unsigned      q;
        int unsigned      d;
        bit               evict;
        wpd_pkg::t_result r;
        p = pos;
        evict = 1'b0;
        distance_run.delete();
        if (new_seq) begin
            win_cnt  = 0;
            win_head = 0;
            prev_ok  = 1'b0;
            ovf_flag = 1'b0;
        end else if (prev_ok && p <= prev_pos) begin
            return;
        end
        while (win_cnt > 0) begin
            q = win_pos[(win_head + DEPTH - win_cnt) % DEPTH];
            if (p >= q && p - q <= gap_hi)
                break;
            win_cnt--;
        end
        if (win_cnt >= DEPTH) begin
            q = win_pos[win_head];
            evict = 1'b1;
            // evicted entry could still pair with a later position
            if (p >= q && p - q < gap_hi)
                ovf_flag = 1'b1;
        end
        for (int k = 0; k < win_cnt; k++) begin
            q = win_pos[(win_head + DEPTH - 1 - k) % DEPTH];
            if (q < p) begin
                d = p - q;
                if (d > gap_lo && d <= gap_hi) begin
                    r.distance   = GW'(d);
                    r.last       = 1'b0;
                    r.overflowed = ovf_flag;
                    distance_run = {distance_run, r};
                end
            end
        end
        if (distance_run.size() > 0)
            distance_run[distance_run.size() - 1].last = 1'b1;
        win_pos[win_head] = pos;
        win_head = (win_head + 1) % DEPTH;
        if (!evict)
            win_cnt++;
        prev_pos = p;
        prev_ok  = 1'b1;
    endfunction

    // offers one word, holds it until taken, then predicts its run
    task automatic drive_word(input logic [POS_W-1:0] pos, input logic new_seq,
                              input bit use_model);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_position     <= pos;
        i_new_sequence <= new_seq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        step_window(pos, new_seq);
        if (use_model)
            pending_distances = {pending_distances, distance_run};
    endtask

    task automatic write_gaps(input logic [GW-1:0] lo, input logic [GW-1:0] hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wpd_pkg::CFG_MIN_GAP;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= wpd_pkg::CFG_MAX_GAP;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gap_lo = lo;
        gap_hi = hi;
    endtask

    // lets the block drain, including words that leave no distance behind
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one ascending sequence with random steps; some words repeat, descend or restart
    task automatic run_sequence(input int len, input int step_max, input int noise_pct);
        int unsigned cur;
        int unsigned span;
        int unsigned back;
        span = len * step_max;
        cur  = $urandom_range(0, POS_MAX - span);
        drive_word(POS_W'(cur), 1'b1, 1'b1);
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 2))
                    0: drive_word(POS_W'(cur), 1'b0, 1'b1);
                    1: begin
                        back = $urandom_range(0, (cur < 50) ? cur : 50);
                        drive_word(POS_W'(cur - back), 1'b0, 1'b1);
                    end
                    default: begin
                        cur = $urandom_range(0, POS_MAX - span);
                        drive_word(POS_W'(cur), 1'b1, 1'b1);
                    end
                endcase
            end else begin
                cur += $urandom_range(1, step_max);
                drive_word(POS_W'(cur), 1'b0, 1'b1);
            end
        end
    endtask

    // result side: random back-pressure and the word by word check
    always @(posedge i_clk) begin
        wpd_pkg::t_result got;
        wpd_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.distance   = o_distance;
            got.last       = o_last;
            got.overflowed = o_window_overflowed;
            if (pending_distances.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: distance %0d last %0b overflowed %0b",
                             got.distance, got.last, got.overflowed);
            end else begin
                want = pending_distances.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0b %0b, got %0d %0b %0b",
                                 want.distance, want.last, want.overflowed,
                                 got.distance, got.last, got.overflowed);
                end
            end
        end
        if (hold_long) begin
            hold_long = 1'b0;
            hold_cnt  = LONG_HOLD - 1;
            i_ready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_cnt = $urandom_range(1, 18) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned      cur;
        wpd_pkg::t_result r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gaps: min 30, max 2000
        for (int i = 0; i < N_ROWS; i++) begin
            drive_word(DIRECTED[i].pos, DIRECTED[i].new_seq, !DIRECTED[i].typed);
            if (DIRECTED[i].typed && DIRECTED[i].one_dist) begin
                r.distance   = DIRECTED[i].exp_gap;
                r.last       = 1'b1;
                r.overflowed = 1'b0;
                pending_distances = {pending_distances, r};
            end
        end
        settle();

        // widest band, with the result side held off long enough to back up the input
        write_gaps(16'd0, 16'hFFFF);
        hold_long = 1'b1;
        run_sequence(8, 200, 0);
        repeat (2) run_sequence($urandom_range(3, 8), 20000, 15);
        settle();

        // empty band: min above max, max at zero
        write_gaps(16'hFFFF, 16'd0);
        run_sequence(6, 100, 20);
        settle();

        // dense sequence fills the window and forces evictions still in range
        write_gaps(16'd20, 16'd1900);
        run_sequence(68, 25, 0);
        run_sequence(8, 400, 20);
        settle();

        // narrower band taken mid-sequence, no idling from here on
        quiet = 1'b1;
        write_gaps(16'd5, 16'd300);
        cur = prev_pos;
        for (int i = 0; i < 6; i++) begin
            cur += $urandom_range(1, 150);
            drive_word(POS_W'(cur), 1'b0, 1'b1);
        end
        run_sequence(8, 300, 10);
        settle();

        if (mismatches == 0 && pending_distances.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ windowed_pair_distance_emitter.f @@
rtl/core/wpd_pkg.sv
rtl/core/wpd_window_ram.sv
rtl/core/wpd_out_stage.sv
rtl/core/wpd_seq.sv
rtl/core/windowed_pair_distance_emitter.sv
test/tb_windowed_pair_distance_emitter.sv
